// File: sv/afe_pkg.sv
// ----------------------------------------------------------------------------
// afe_pkg: shared types and codes for the aging FIFO
// Operation and status codes, age width and the per-cell control bundle.
// ----------------------------------------------------------------------------
package afe_pkg;

    localparam int AGE_W = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd3;
    localparam logic [AGE_W-1:0] AGE_SAT       = 8'd255;

    // Control broadcast to every cell of the chain; at most one bit is set.
    typedef struct packed {
        logic insert;   // fill the first empty cell
        logic tick;     // age every occupied cell
        logic shift;    // advance every cell one place toward the head
    } afe_cell_ctrl_t;

endpackage

// File: sv/afe_cell.sv
// ----------------------------------------------------------------------------
// afe_cell: one entry of the aging FIFO chain
// Holds valid, payload and age; loads from its tail-side neighbor on shift.
// ----------------------------------------------------------------------------
module afe_cell
    import afe_pkg::*;
#(
    parameter int PW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  afe_cell_ctrl_t   ctrl,
    input  logic [AGE_W-1:0] limit,
    input  logic             prev_valid,
    input  logic [PW-1:0]    ins_title,
    input  logic [PW-1:0]    ins_text,
    input  logic             nxt_valid,
    input  logic [PW-1:0]    nxt_title,
    input  logic [PW-1:0]    nxt_text,
    input  logic [AGE_W-1:0] nxt_age,
    output logic             valid,
    output logic [PW-1:0]    title,
    output logic [PW-1:0]    text,
    output logic [AGE_W-1:0] age
);

    logic             valid_reg, valid_next;
    logic [PW-1:0]    title_reg, title_next;
    logic [PW-1:0]    text_reg, text_next;
    logic [AGE_W-1:0] age_reg, age_next;

    always_comb
    begin
        valid_next = valid_reg;
        title_next = title_reg;
        text_next  = text_reg;
        age_next   = age_reg;
        if (ctrl.shift)
        begin
            valid_next = nxt_valid;
            title_next = nxt_title;
            text_next  = nxt_text;
            age_next   = nxt_age;
        end
        else if (ctrl.insert && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            title_next = ins_title;
            text_next  = ins_text;
            age_next   = '0;
        end
        else if (ctrl.tick && valid_reg && (age_reg < limit))
        begin
            age_next = age_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        title_reg <= title_next;
        text_reg  <= text_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign title = title_reg;
    assign text  = text_reg;
    assign age   = age_reg;

endmodule

// File: sv/aging_fifo_with_expiry_core.sv
// ----------------------------------------------------------------------------
// aging_fifo_with_expiry_core: bounded FIFO whose entries expire by age
// Insert, age tick and remove over a chain of DEPTH cells, head at cell 0.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, op, title_in, text_in | to core
//  out     | out_valid, out_ready, status, title_out,  | from core
//          | text_out                                  |
//  cfg     | cfg_valid, cfg_ready, cfg_data (max_age)  | to core
//
//  Insert, tick and no-op finish in the cycle their transaction is taken;
//  the result sits in the output register from the following cycle.
//  Remove drops the expired head entries (up to DEPTH), then pops the head
//  or reports empty: the cell chain advances one place per cycle.
//  Reset clears every cell's valid bit and loads max_age with 3.
//  A stalled result holds in the output register; a new transaction is
//  taken only in the idle state while that register is free or being emptied.
//
module aging_fifo_with_expiry_core
    import afe_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] title_in,
    input  logic [31:0] text_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] title_out,
    output logic [31:0] text_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    typedef enum logic {S_IDLE, S_REMOVE} state_t;

    state_t             state_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [31:0]        title_reg;
    logic [31:0]        text_reg;
    logic [AGE_W-1:0]   max_age_reg;

    logic [DEPTH-1:0]         cell_valid;
    logic [PAYLOAD_WIDTH-1:0] cell_title [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_text  [DEPTH];
    logic [AGE_W-1:0]         cell_age   [DEPTH];

    afe_cell_ctrl_t           ctrl;
    logic                     accept_in;
    logic                     full;
    logic                     head_expired;
    logic [AGE_W-1:0]         limit;
    logic [63:0]              title_wide, text_wide;
    logic [63:0]              head_title_wide, head_text_wide;

    // Mask payloads to the stored width, then back to the 32-bit fields.
    assign title_wide      = {32'b0, title_in};
    assign text_wide       = {32'b0, text_in};
    assign head_title_wide = 64'(cell_title[0]);
    assign head_text_wide  = 64'(cell_text[0]);

    assign full         = cell_valid[DEPTH-1];
    assign head_expired = cell_age[0] > max_age_reg;
    assign limit        = (max_age_reg == AGE_SAT) ? AGE_SAT : max_age_reg + 1'b1;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept_in = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign ctrl.insert = accept_in && (op == OP_INSERT) && !full;
    assign ctrl.tick   = accept_in && (op == OP_TICK);
    // Advance the chain while removing: drops an expired head or pops a fresh one.
    assign ctrl.shift  = (state_reg == S_REMOVE) && cell_valid[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     prev_valid;
        logic                     nxt_valid;
        logic [PAYLOAD_WIDTH-1:0] nxt_title, nxt_text;
        logic [AGE_W-1:0]         nxt_age;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_rest
            assign prev_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign nxt_valid = 1'b0;
            assign nxt_title = '0;
            assign nxt_text  = '0;
            assign nxt_age   = '0;
        end
        else
        begin : g_inner
            assign nxt_valid = cell_valid[i+1];
            assign nxt_title = cell_title[i+1];
            assign nxt_text  = cell_text[i+1];
            assign nxt_age   = cell_age[i+1];
        end

        afe_cell #(
            .PW (PAYLOAD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .limit      (limit),
            .prev_valid (prev_valid),
            .ins_title  (title_wide[PAYLOAD_WIDTH-1:0]),
            .ins_text   (text_wide[PAYLOAD_WIDTH-1:0]),
            .nxt_valid  (nxt_valid),
            .nxt_title  (nxt_title),
            .nxt_text   (nxt_text),
            .nxt_age    (nxt_age),
            .valid      (cell_valid[i]),
            .title      (cell_title[i]),
            .text       (cell_text[i]),
            .age        (cell_age[i])
        );
    end

    // Sender must write max_age only while nothing is in flight; unchecked here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= MAX_AGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_age_reg <= cfg_data;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            title_reg     <= '0;
            text_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        title_reg <= '0;
                        text_reg  <= '0;
                        unique case (op)
                            OP_INSERT:
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= full ? STATUS_FULL : STATUS_OK;
                            end
                            OP_TICK, OP_NOP:
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= STATUS_OK;
                            end
                            OP_REMOVE:
                            begin
                                // The register is free or being emptied here.
                                out_valid_reg <= 1'b0;
                                state_reg     <= S_REMOVE;
                            end
                        endcase
                    end
                    else if (out_valid_reg && out_ready)
                    begin
                        // Drop the delivered result.
                        out_valid_reg <= 1'b0;
                    end
                end
                S_REMOVE:
                begin
                    priority if (cell_valid[0] && head_expired)
                    begin
                        // Hold: the shift discards the stale head this cycle.
                        state_reg <= S_REMOVE;
                    end
                    else if (cell_valid[0])
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= STATUS_OK;
                        title_reg     <= head_title_wide[31:0];
                        text_reg      <= head_text_wide[31:0];
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= STATUS_EMPTY;
                        title_reg     <= '0;
                        text_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign title_out = title_reg;
    assign text_out  = text_reg;

    // Occupied cells stay packed toward the head.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & ~{cell_valid[DEPTH-2:0], 1'b1}) == '0)
        else $error("occupied cells not contiguous from head");

    // The output register is always free while a remove is in progress.
    a_remove_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |-> !out_valid_reg)
        else $error("result pending during remove");

    // An accepted insert into a non-full chain adds exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && (op == OP_INSERT) && !full) |=>
        ($countones(cell_valid) == $past($countones(cell_valid)) + 1))
        else $error("insert did not add one entry");

    // A full status is only reported when the last cell was occupied.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && (op == OP_INSERT)) |=> ((status_reg == STATUS_FULL) == $past(full)))
        else $error("full status mismatch");

endmodule
